// File: design/tkl_pkg.sv
// Shared types and constants for the top-k leaderboard table.
`timescale 1ns / 1ps

package tkl_pkg;

    // Field widths fixed by the item format
    localparam int ID_W     = 16;
    localparam int SCORE_W  = 32;
    localparam int RANK_W   = 4;
    localparam int STATUS_W = 2;

    // Default number of table entries
    localparam int DEF_TABLE_SIZE = 10;

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ENTERED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOPLACE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_READ     = 2'd3;

    // One table entry as stored in the memory
    typedef struct packed {
        logic [ID_W-1:0]           id;
        logic signed [SCORE_W-1:0] score;
    } entry_t;

    // Memory port strobes
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } ram_ctl_t;

    // One result item
    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [RANK_W-1:0]         placed_rank;
        logic                      new_top;
        logic                      tied_top;
        logic [ID_W-1:0]           out_id;
        logic signed [SCORE_W-1:0] out_score;
        logic [RANK_W-1:0]         entry_total;
    } result_t;

endpackage

// File: design/top_k_sorted_leaderboard_unit.sv
// Top level of the top-k leaderboard table: ports and output register.
`timescale 1ns / 1ps
//
// Keeps up to TABLE_SIZE (id, score) entries sorted by descending signed
// Q16.16 score in a single-port-read, single-port-write memory.
// Input channel (s_*): cmd 0 inserts player_id/new_score, cmd 1 reads the
// entry at read_index. Result channel (m_*): one item per input item with
// status, placed rank, top flags, read data and the entry count.
// An item is handled one at a time by the sequencer. A read fetches its
// entry through S_RDWAIT; a read_index past the held entries goes straight
// to the result. An insert into a table of n entries reads each one once for
// the duplicate and rank check, then moves the s entries below the new rank
// one slot down, with each read overlapping the write of the entry before
// it. An insert into an empty table skips the scan. The next item is taken
// in the cycle after its result enters the output register.
// A finished result sits in the output register; the next item is taken
// while it waits. If m_ready stays low, the following result is held in the
// sequencer and s_ready stays low until the output register frees up.
// Reset (aresetn low, synchronous) empties the table; memory contents are
// not cleared, since entries past the count are never exposed.
//

module top_k_sorted_leaderboard_unit #(
    parameter int TABLE_SIZE = tkl_pkg::DEF_TABLE_SIZE
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_cmd,
    input  logic [tkl_pkg::ID_W-1:0]             s_player_id,
    input  logic signed [tkl_pkg::SCORE_W-1:0]   s_new_score,
    input  logic [tkl_pkg::RANK_W-1:0]           s_read_index,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [tkl_pkg::STATUS_W-1:0]         m_status,
    output logic [tkl_pkg::RANK_W-1:0]           m_placed_rank,
    output logic                                 m_new_top,
    output logic                                 m_tied_top,
    output logic [tkl_pkg::ID_W-1:0]             m_out_id,
    output logic signed [tkl_pkg::SCORE_W-1:0]   m_out_score,
    output logic [tkl_pkg::RANK_W-1:0]           m_entry_total
);

    logic             res_valid;
    logic             res_ready;
    tkl_pkg::result_t res;

    logic             m_valid_reg, m_valid_next;
    tkl_pkg::result_t out_reg, out_next;

    tkl_engine #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_cmd    (s_cmd),
        .in_id     (s_player_id),
        .in_score  (s_new_score),
        .in_ridx   (s_read_index),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Load a new result when the register is empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = out_reg.status;
    assign m_placed_rank = out_reg.placed_rank;
    assign m_new_top     = out_reg.new_top;
    assign m_tied_top    = out_reg.tied_top;
    assign m_out_id      = out_reg.out_id;
    assign m_out_score   = out_reg.out_score;
    assign m_entry_total = out_reg.entry_total;

endmodule

// File: design/tkl_entry_ram.sv
// Entry memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module tkl_entry_ram #(
    parameter int DEPTH  = tkl_pkg::DEF_TABLE_SIZE,
    parameter int ADDR_W = $clog2(tkl_pkg::DEF_TABLE_SIZE)
) (
    input  logic                aclk,
    input  tkl_pkg::ram_ctl_t   ctl,
    input  logic [ADDR_W-1:0]   rd_addr,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  tkl_pkg::entry_t     wr_data,
    output tkl_pkg::entry_t     rd_data
);

    tkl_pkg::entry_t mem [DEPTH];

    // Write and read, read data registered
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: design/tkl_engine.sv
// Sequencer: scans, shifts and places entries in the table memory.
`timescale 1ns / 1ps

module tkl_engine #(
    parameter int TABLE_SIZE = tkl_pkg::DEF_TABLE_SIZE
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // item intake
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 in_cmd,
    input  logic [tkl_pkg::ID_W-1:0]             in_id,
    input  logic signed [tkl_pkg::SCORE_W-1:0]   in_score,
    input  logic [tkl_pkg::RANK_W-1:0]           in_ridx,
    // result handoff
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output tkl_pkg::result_t                     res
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int CNT_W = $clog2(TABLE_SIZE + 1);
    localparam int CMP_W = (CNT_W > tkl_pkg::RANK_W) ? CNT_W : tkl_pkg::RANK_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_SIZE);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_PLACE  = 3'd4;
    localparam logic [2:0] S_RDWAIT = 3'd5;
    localparam logic [2:0] S_RESULT = 3'd6;

    // control state
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             iss_reg, iss_next;
    logic             pend_reg, pend_next;

    // working registers
    logic [tkl_pkg::ID_W-1:0]           id_reg, id_next;
    logic signed [tkl_pkg::SCORE_W-1:0] score_reg, score_next;
    logic [IDX_W-1:0]                   ptr_reg, ptr_next;
    logic [IDX_W-1:0]                   pend_idx_reg, pend_idx_next;
    logic [CNT_W-1:0]                   pos_reg, pos_next;
    logic                               dup_reg, dup_next;
    logic                               gt_top_reg, gt_top_next;
    logic                               eq_top_reg, eq_top_next;
    logic                               gt_worst_reg, gt_worst_next;
    tkl_pkg::result_t                   res_reg, res_next;

    // memory port
    tkl_pkg::ram_ctl_t ram_ctl;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;
    tkl_pkg::entry_t   wr_data;
    tkl_pkg::entry_t   rd_data;

    logic [CNT_W-1:0] cnt_m1;
    logic [CNT_W-1:0] last_cnt;
    logic [CMP_W-1:0] ridx_ext;
    logic             full;
    logic             enters;

    tkl_entry_ram #(
        .DEPTH  (TABLE_SIZE),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .ctl     (ram_ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESULT);
    assign res       = res_reg;

    assign cnt_m1   = count_reg - CNT_W'(1);
    assign full     = (count_reg == FULL_CNT);
    assign last_cnt = full ? CNT_W'(TABLE_SIZE - 1) : count_reg;
    assign ridx_ext = CMP_W'(in_ridx);
    assign enters   = (count_reg == '0) || !full || gt_worst_reg;

    // Sequence one item
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        iss_next      = iss_reg;
        pend_next     = pend_reg;
        id_next       = id_reg;
        score_next    = score_reg;
        ptr_next      = ptr_reg;
        pend_idx_next = pend_idx_reg;
        pos_next      = pos_reg;
        dup_next      = dup_reg;
        gt_top_next   = gt_top_reg;
        eq_top_next   = eq_top_reg;
        gt_worst_next = gt_worst_reg;
        res_next      = res_reg;
        ram_ctl       = '0;
        rd_addr       = ptr_reg;
        wr_addr       = pend_idx_reg + IDX_W'(1);
        wr_data       = rd_data;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    id_next       = in_id;
                    score_next    = in_score;
                    ptr_next      = '0;
                    pos_next      = '0;
                    dup_next      = 1'b0;
                    gt_top_next   = 1'b0;
                    eq_top_next   = 1'b0;
                    gt_worst_next = 1'b0;
                    pend_next     = 1'b0;
                    res_next      = '0;
                    res_next.entry_total = tkl_pkg::RANK_W'(count_reg);
                    if (in_cmd == tkl_pkg::CMD_READ) begin
                        res_next.status = tkl_pkg::ST_READ;
                        if (ridx_ext < CMP_W'(count_reg)) begin
                            // fetch the entry now, capture it next cycle
                            ram_ctl.rd_en = 1'b1;
                            rd_addr       = ridx_ext[IDX_W-1:0];
                            state_next    = S_RDWAIT;
                        end else begin
                            state_next = S_RESULT;
                        end
                    end else if (count_reg == '0) begin
                        state_next = S_DECIDE;
                    end else begin
                        iss_next   = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // issue reads over all held entries
                if (iss_reg) begin
                    ram_ctl.rd_en = 1'b1;
                    rd_addr       = ptr_reg;
                    if (ptr_reg == cnt_m1[IDX_W-1:0]) begin
                        iss_next = 1'b0;
                    end else begin
                        ptr_next = ptr_reg + IDX_W'(1);
                    end
                end
                pend_next     = iss_reg;
                pend_idx_next = ptr_reg;
                // check the entry that came back
                if (pend_reg) begin
                    if (rd_data.id == id_reg) begin
                        dup_next = 1'b1;
                    end
                    if (rd_data.score >= score_reg) begin
                        pos_next = pos_reg + CNT_W'(1);
                    end
                    if (pend_idx_reg == '0) begin
                        gt_top_next = (score_reg > rd_data.score);
                        eq_top_next = (score_reg == rd_data.score);
                    end
                    if (pend_idx_reg == cnt_m1[IDX_W-1:0]) begin
                        gt_worst_next = (score_reg > rd_data.score);
                    end
                end
                if (!iss_reg && !pend_reg) begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE: begin
                if (dup_reg) begin
                    res_next.status = tkl_pkg::ST_DUP;
                    state_next      = S_RESULT;
                end else begin
                    res_next.new_top  = (count_reg == '0) || gt_top_reg;
                    res_next.tied_top = (count_reg != '0) && eq_top_reg;
                    if (!enters) begin
                        res_next.status = tkl_pkg::ST_NOPLACE;
                        state_next      = S_RESULT;
                    end else if (last_cnt > pos_reg) begin
                        // move entries down from the last held slot (the one before it when full) to pos
                        iss_next   = 1'b1;
                        pend_next  = 1'b0;
                        ptr_next   = cnt_m1[IDX_W-1:0];
                        if (full) begin
                            ptr_next = IDX_W'(TABLE_SIZE - 2);
                        end
                        state_next = S_SHIFT;
                    end else begin
                        state_next = S_PLACE;
                    end
                end
            end

            S_SHIFT: begin
                // read source entries downward
                if (iss_reg) begin
                    ram_ctl.rd_en = 1'b1;
                    rd_addr       = ptr_reg;
                    if (ptr_reg == pos_reg[IDX_W-1:0]) begin
                        iss_next = 1'b0;
                    end else begin
                        ptr_next = ptr_reg - IDX_W'(1);
                    end
                end
                pend_next     = iss_reg;
                pend_idx_next = ptr_reg;
                // write each one a slot lower
                if (pend_reg) begin
                    ram_ctl.wr_en = 1'b1;
                    wr_addr       = pend_idx_reg + IDX_W'(1);
                    wr_data       = rd_data;
                end
                if (!iss_reg && !pend_reg) begin
                    state_next = S_PLACE;
                end
            end

            S_PLACE: begin
                ram_ctl.wr_en    = 1'b1;
                wr_addr          = pos_reg[IDX_W-1:0];
                wr_data.id       = id_reg;
                wr_data.score    = score_reg;
                count_next       = full ? count_reg : count_reg + CNT_W'(1);
                res_next.status      = tkl_pkg::ST_ENTERED;
                res_next.placed_rank = tkl_pkg::RANK_W'(pos_reg);
                res_next.entry_total = tkl_pkg::RANK_W'(count_next);
                state_next       = S_RESULT;
            end

            S_RDWAIT: begin
                res_next.out_id    = rd_data.id;
                res_next.out_score = rd_data.score;
                state_next         = S_RESULT;
            end

            S_RESULT: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            iss_reg   <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            iss_reg   <= iss_next;
            pend_reg  <= pend_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        id_reg       <= id_next;
        score_reg    <= score_next;
        ptr_reg      <= ptr_next;
        pend_idx_reg <= pend_idx_next;
        pos_reg      <= pos_next;
        dup_reg      <= dup_next;
        gt_top_reg   <= gt_top_next;
        eq_top_reg   <= eq_top_next;
        gt_worst_reg <= gt_worst_next;
        res_reg      <= res_next;
    end

endmodule
